>>> design/md5_pkg.sv
package md5_pkg;

    localparam int BUF_WORDS = 16;
    localparam int BUF_AW    = $clog2(BUF_WORDS);

    // chaining values after reset and after every digest
    localparam logic [31:0] MD5_IV [4] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476
    };

    localparam logic [7:0]        PAD_BYTE    = 8'h80;
    localparam logic [5:0]        LAST_BYTE   = 6'd63;
    localparam logic [5:0]        PAD_LIMIT   = 6'd56;
    localparam logic [5:0]        LAST_ROUND  = 6'd63;
    localparam logic [BUF_AW-1:0] LEN_LO_WORD = BUF_AW'(14);
    localparam logic [BUF_AW-1:0] LEN_HI_WORD = BUF_AW'(15);
    localparam logic [BUF_AW-1:0] LAST_WORD   = BUF_AW'(BUF_WORDS - 1);
    localparam logic [63:0]       BYTE_BITS   = 64'd8;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } md5_state_t;

    localparam logic [31:0] ROUND_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // rotate amounts by group and position within a group of four
    localparam logic [4:0] ROUND_S [4][4] = '{
        '{5'd7, 5'd12, 5'd17, 5'd22},
        '{5'd5, 5'd9,  5'd14, 5'd20},
        '{5'd4, 5'd11, 5'd16, 5'd23},
        '{5'd6, 5'd10, 5'd15, 5'd21}
    };

    function automatic logic [BUF_AW-1:0] msg_index(input logic [5:0] rnd);
        logic [3:0] r4;
        logic [3:0] idx;
        r4 = rnd[3:0];
        unique case (rnd[5:4])
            2'd0: idx = r4;
            2'd1: idx = 4'd5 * r4 + 4'd1;
            2'd2: idx = 4'd3 * r4 + 4'd5;
            2'd3: idx = 4'd7 * r4;
            default: idx = r4;
        endcase
        return BUF_AW'(idx);
    endfunction

    function automatic logic [4:0] round_shift(input logic [5:0] rnd);
        return ROUND_S[rnd[5:4]][rnd[1:0]];
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
        return (x << s) | (x >> (6'd32 - {1'b0, s}));
    endfunction

endpackage

>>> design/md5_buf_ram.sv
module md5_buf_ram (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [md5_pkg::BUF_AW-1:0] wr_addr,
    input  logic [31:0]               wr_data,
    input  logic [md5_pkg::BUF_AW-1:0] rd_addr,
    output logic [31:0]               rd_data
);
    import md5_pkg::*;

    logic [31:0] mem [BUF_WORDS];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> design/md5_round.sv
module md5_round (
    input  md5_pkg::md5_state_t st,
    input  logic [31:0]         msg,
    input  logic [5:0]          rnd,
    output md5_pkg::md5_state_t nxt
);
    import md5_pkg::*;

    logic [31:0] f;
    logic [31:0] sum;

    always_comb begin
        unique case (rnd[5:4])
            2'd0: f = (st.b & st.c) | (~st.b & st.d);
            2'd1: f = (st.d & st.b) | (~st.d & st.c);
            2'd2: f = st.b ^ st.c ^ st.d;
            2'd3: f = st.c ^ (st.b | ~st.d);
            default: f = '0;
        endcase
        sum   = st.a + f + ROUND_K[rnd] + msg;
        nxt.a = st.d;
        nxt.b = st.b + rotl32(sum, round_shift(rnd));
        nxt.c = st.b;
        nxt.d = st.c;
    end

endmodule

>>> design/md5_message_digest_top.sv
// sequence: a byte beat is taken in ST_IDLE; a beat that fills the 64-byte block
//   starts compression (a load, 64 rounds at one per cycle, a chain add)
// end of message: pad words from word fill/4 to the last word, fill counting the last byte,
//   then compression; another block of zeros and length when fill >= 56, then 4 digest beats
// no byte is taken while a block is padded or compressed or the digest goes out
// reset: aresetn synchronous, active low; chaining words return to the iv,
//   counts clear, no clearing pass over the block buffer is needed
module md5_message_digest_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic [0:0]  s_tuser,   // byte_present
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // digest_word
    output logic [1:0]  m_tuser,   // word_index
    output logic        m_tlast    // last_word
);
    import md5_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,   // taking byte beats
        ST_PAD,    // writing padding and length words
        ST_CPRE,   // load working words, first message read in flight
        ST_CRND,   // one round per cycle
        ST_CFIN,   // add into chaining words
        ST_OUT     // handing out digest beats
    } state_t;

    state_t      state_reg;
    logic [5:0]  fill_reg;        // bytes held in the current block
    logic [63:0] bit_len_reg;
    logic [31:0] word_reg;        // word under assembly
    logic [BUF_AW-1:0] pad_idx_reg;
    logic        pad_first_reg;   // next pad word carries the 0x80 marker
    logic        pad_len_reg;     // this pad pass ends in the bit length
    logic        need_more_reg;   // a length-only block still follows
    logic        pad_todo_reg;    // message ended on a full block
    logic        fin_reg;         // message end seen
    logic [5:0]  rnd_reg;
    md5_state_t  work_reg;
    logic [31:0] chain_reg [4];
    logic [1:0]  out_idx_reg;
    logic        m_valid_reg;
    logic [31:0] m_data_reg;
    logic        m_last_reg;

    logic        s_accept;
    logic [1:0]  lane;
    logic [5:0]  fill_after;
    logic [5:0]  pad_from;
    logic [31:0] word_ins;
    logic [31:0] pad_word;
    logic [31:0] pad_val;
    logic        wr_en;
    logic [BUF_AW-1:0] wr_addr;
    logic [31:0] wr_data;
    logic [BUF_AW-1:0] rd_addr;
    logic [31:0] msg_word;
    md5_state_t  round_out;
    logic [31:0] chain_sum [4];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign lane     = fill_reg[1:0];
    assign fill_after = s_tuser[0] ? fill_reg + 6'd1 : fill_reg;
    // padding starts from the fill after this beat, or from an empty block
    assign pad_from = (state_reg == ST_CFIN) ? fill_reg : fill_after;

    // drop the byte into its lane of the word under assembly
    always_comb begin
        word_ins = word_reg;
        word_ins[{lane, 3'b000} +: 8] = s_tdata;
    end

    // first pad word keeps the bytes below the fill, then 0x80, then zeros
    always_comb begin
        for (int l = 0; l < 4; l++) begin
            if (2'(l) < lane) begin
                pad_word[8*l +: 8] = word_reg[8*l +: 8];
            end else if (2'(l) == lane) begin
                pad_word[8*l +: 8] = PAD_BYTE;
            end else begin
                pad_word[8*l +: 8] = 8'h00;
            end
        end
    end

    always_comb begin
        if (pad_first_reg) begin
            pad_val = pad_word;
        end else if (pad_len_reg && pad_idx_reg == LEN_LO_WORD) begin
            pad_val = bit_len_reg[31:0];
        end else if (pad_len_reg && pad_idx_reg == LEN_HI_WORD) begin
            pad_val = bit_len_reg[63:32];
        end else begin
            pad_val = '0;
        end
    end

    // a word goes to the buffer when its top lane fills, or on each pad cycle
    assign wr_en   = (s_accept && s_tuser[0] && lane == 2'd3) || (state_reg == ST_PAD);
    assign wr_addr = (state_reg == ST_PAD) ? pad_idx_reg : fill_reg[5:2];
    assign wr_data = (state_reg == ST_PAD) ? pad_val : word_ins;

    // read one round ahead so the word lands as the round needs it
    assign rd_addr = msg_index((state_reg == ST_CRND) ? rnd_reg + 6'd1 : 6'd0);

    md5_buf_ram u_buf (
        .clk     (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (msg_word)
    );

    md5_round u_round (
        .st  (work_reg),
        .msg (msg_word),
        .rnd (rnd_reg),
        .nxt (round_out)
    );

    assign chain_sum[0] = chain_reg[0] + work_reg.a;
    assign chain_sum[1] = chain_reg[1] + work_reg.b;
    assign chain_sum[2] = chain_reg[2] + work_reg.c;
    assign chain_sum[3] = chain_reg[3] + work_reg.d;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            bit_len_reg   <= '0;
            pad_first_reg <= 1'b0;
            pad_len_reg   <= 1'b0;
            need_more_reg <= 1'b0;
            pad_todo_reg  <= 1'b0;
            fin_reg       <= 1'b0;
            rnd_reg       <= '0;
            out_idx_reg   <= '0;
            m_valid_reg   <= 1'b0;
            m_last_reg    <= 1'b0;
            for (int k = 0; k < 4; k++) begin
                chain_reg[k] <= MD5_IV[k];
            end
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        if (s_tuser[0]) begin
                            word_reg    <= word_ins;
                            bit_len_reg <= bit_len_reg + BYTE_BITS;
                            fill_reg    <= fill_after;
                        end
                        if (s_tuser[0] && fill_reg == LAST_BYTE) begin
                            // block full: compress, pad afterwards if the message ends here
                            pad_todo_reg <= s_tlast;
                            fin_reg      <= s_tlast;
                            state_reg    <= ST_CPRE;
                        end else if (s_tlast) begin
                            fin_reg       <= 1'b1;
                            pad_idx_reg   <= pad_from[5:2];
                            pad_first_reg <= 1'b1;
                            pad_len_reg   <= (pad_from < PAD_LIMIT);
                            need_more_reg <= !(pad_from < PAD_LIMIT);
                            state_reg     <= ST_PAD;
                        end
                    end
                end
                ST_PAD: begin
                    pad_first_reg <= 1'b0;
                    if (pad_idx_reg == LAST_WORD) begin
                        state_reg <= ST_CPRE;
                    end else begin
                        pad_idx_reg <= pad_idx_reg + 1'b1;
                    end
                end
                ST_CPRE: begin
                    work_reg  <= '{a: chain_reg[0], b: chain_reg[1],
                                   c: chain_reg[2], d: chain_reg[3]};
                    rnd_reg   <= '0;
                    state_reg <= ST_CRND;
                end
                ST_CRND: begin
                    work_reg <= round_out;
                    rnd_reg  <= rnd_reg + 6'd1;
                    if (rnd_reg == LAST_ROUND) begin
                        state_reg <= ST_CFIN;
                    end
                end
                ST_CFIN: begin
                    for (int k = 0; k < 4; k++) begin
                        chain_reg[k] <= chain_sum[k];
                    end
                    if (pad_todo_reg) begin
                        // message ended on a block boundary, pad an empty block
                        pad_todo_reg  <= 1'b0;
                        pad_idx_reg   <= pad_from[5:2];
                        pad_first_reg <= 1'b1;
                        pad_len_reg   <= (pad_from < PAD_LIMIT);
                        need_more_reg <= !(pad_from < PAD_LIMIT);
                        state_reg     <= ST_PAD;
                    end else if (need_more_reg) begin
                        // length did not fit, one more block of zeros and length
                        need_more_reg <= 1'b0;
                        pad_idx_reg   <= '0;
                        pad_first_reg <= 1'b0;
                        pad_len_reg   <= 1'b1;
                        state_reg     <= ST_PAD;
                    end else if (fin_reg) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= chain_sum[0];
                        m_last_reg  <= 1'b0;
                        out_idx_reg <= '0;
                        state_reg   <= ST_OUT;
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_OUT: begin
                    if (m_tready) begin
                        if (out_idx_reg == 2'd3) begin
                            // digest delivered, back to the initial state
                            m_valid_reg <= 1'b0;
                            m_last_reg  <= 1'b0;
                            fin_reg     <= 1'b0;
                            fill_reg    <= '0;
                            bit_len_reg <= '0;
                            for (int k = 0; k < 4; k++) begin
                                chain_reg[k] <= MD5_IV[k];
                            end
                            state_reg <= ST_IDLE;
                        end else begin
                            out_idx_reg <= out_idx_reg + 2'd1;
                            m_data_reg  <= chain_reg[out_idx_reg + 2'd1];
                            m_last_reg  <= (out_idx_reg == 2'd2);
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = out_idx_reg;
    assign m_tlast  = m_last_reg;

endmodule

>>> design/md5_chk.sv
module md5_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // stalled digest beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("digest beat changed while stalled");

    // no message byte is taken while the digest is going out
    a_no_input_during_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input ready while digest pending");

    // words follow one another in order without a gap
    a_word_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tuser == 2'($past(m_tuser) + 2'd1))
        else $error("digest word out of order");

    // last flag sits on the fourth word only
    a_last_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser == 2'd3)))
        else $error("last flag on wrong word");

    // after the final word the block takes a new message at once
    a_back_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
        else $error("not ready after digest");

endmodule

bind md5_message_digest_top md5_chk u_md5_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
